FILE: rtl/c8eu_pkg.sv
package c8eu_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int FLAG_REGS_DEFAULT   = 8;
   localparam logic [15:0] PC_RESET   = 16'h0200;
   localparam logic [16:0] INDEX_LIMIT = 17'd999;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNDEF   = 3'd1,
      ST_OUTSIDE = 3'd2,
      ST_STACK   = 3'd3,
      ST_WAIT    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_VF_RESET  = 2'd0,
      CSR_SHIFT     = 2'd1,
      CSR_JUMP_VX   = 2'd2,
      CSR_INDEX_OVF = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SAVE,
      FSM_RESTORE,
      FSM_DONE
   } fsm_state_type;

   typedef struct packed {
      logic [15:0] instr;
      logic [15:0] keys_held;
      logic [4:0]  released_key;
      logic [7:0]  rand_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] pc_out;
      logic [15:0] index_out;
      logic [3:0]  dest_reg;
      logic [7:0]  dest_value;
      logic [7:0]  flag_value;
      logic        skipped;
      logic [7:0]  delay_value;
      logic        sound_on;
   } rsp_payload_type;

   typedef struct packed {
      logic       vf_reset_quirk;
      logic       shift_in_place;
      logic       jump_with_vx;
      logic       index_overflow_quirk;
   } quirk_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic tick;     // run timers
      logic exec;     // execute captured instruction
      logic save;     // copy one flag register out
      logic restore;  // copy one flag register in
      logic [3:0] walk;
      logic emit;     // load result into response register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic save_op;
      logic restore_op;
      logic [3:0] walk_last;
   } dp_status_type;

   typedef struct packed {
      logic        op;
      req_payload_type payload;
   } req_item_type;

endpackage

FILE: rtl/c8eu_if.sv
interface c8eu_req_if;
   import c8eu_pkg::*;
   logic         valid;
   logic         ready;
   logic         op;
   logic [15:0]  instr;
   logic [15:0]  keys_held;
   logic [4:0]   released_key;
   logic [7:0]   rand_byte;
   modport source (output valid, op, instr, keys_held, released_key, rand_byte, input ready);
   modport sink   (input valid, op, instr, keys_held, released_key, rand_byte, output ready);
endinterface

interface c8eu_rsp_if;
   logic         valid;
   logic         ready;
   logic [2:0]   status;
   logic [15:0]  pc_out;
   logic [15:0]  index_out;
   logic [3:0]   dest_reg;
   logic [7:0]   dest_value;
   logic [7:0]   flag_value;
   logic         skipped;
   logic [7:0]   delay_value;
   logic         sound_on;
   modport source (output valid, status, pc_out, index_out, dest_reg, dest_value, flag_value,
                   skipped, delay_value, sound_on, input ready);
   modport sink   (input valid, status, pc_out, index_out, dest_reg, dest_value, flag_value,
                   skipped, delay_value, sound_on, output ready);
endinterface

interface c8eu_csr_if;
   logic         valid;
   logic         ready;
   logic [1:0]   index;
   logic         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/c8eu_ctrl.sv
module c8eu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_op,
   output logic                     req_ready,
   input  logic                     rsp_slot_free,
   input  c8eu_pkg::dp_status_type  status_in,
   output c8eu_pkg::dp_cmd_type     cmd,
   output c8eu_pkg::fsm_state_type  state_out
);
   import c8eu_pkg::*;

   fsm_state_type state_ff, state_in;
   logic [3:0]    walk_ff, walk_in;
   logic          tick_ff, tick_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         walk_ff  <= '0;
         tick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
         tick_ff  <= tick_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      walk_in   = walk_ff;
      tick_in   = tick_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.walk  = walk_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               tick_in  = req_op;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            walk_in = '0;
            if (tick_ff) begin
               cmd.tick = 1'b1;
               state_in = FSM_DONE;
            end else if (status_in.save_op) begin
               state_in = FSM_SAVE;
            end else if (status_in.restore_op) begin
               state_in = FSM_RESTORE;
            end else begin
               cmd.exec = 1'b1;
               state_in = FSM_DONE;
            end
         end
         FSM_SAVE: begin
            cmd.save = 1'b1;
            walk_in  = walk_ff + 4'd1;
            if (walk_ff == status_in.walk_last) state_in = FSM_DONE;
         end
         FSM_RESTORE: begin
            cmd.restore = 1'b1;
            walk_in     = walk_ff + 4'd1;
            if (walk_ff == status_in.walk_last) state_in = FSM_DONE;
         end
         FSM_DONE: begin
            if (rsp_slot_free) begin
               cmd.emit = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   assign state_out = state_ff;
endmodule

FILE: rtl/c8eu_datapath.sv
module c8eu_datapath #(
   parameter int STACK_DEPTH = c8eu_pkg::STACK_DEPTH_DEFAULT,
   parameter int FLAG_REGS   = c8eu_pkg::FLAG_REGS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  c8eu_pkg::dp_cmd_type      cmd,
   input  c8eu_pkg::req_payload_type req_in,
   input  c8eu_pkg::quirk_type       quirk,
   output c8eu_pkg::dp_status_type   status_out,
   output c8eu_pkg::rsp_payload_type result,
   output logic [$clog2(STACK_DEPTH+1)-1:0] level_out
);
   import c8eu_pkg::*;

   localparam int LW = $clog2(STACK_DEPTH + 1);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FW = (FLAG_REGS > 1) ? $clog2(FLAG_REGS) : 1;
   localparam logic [4:0] FLAG_LAST = 5'(FLAG_REGS - 1);

   req_payload_type req_ff;
   logic [7:0]  gp_ff [16];
   logic [7:0]  saved_ff [FLAG_REGS];
   logic [15:0] stack_mem [STACK_DEPTH];
   logic [15:0] pc_ff, index_ff;
   logic [7:0]  delay_ff, sound_ff;
   logic [LW-1:0] level_ff;
   logic [2:0]  status_ff;
   logic [3:0]  dreg_ff;
   logic        dwr_ff;
   logic        skip_ff;

   logic [3:0]  hi, x, y, n;
   logic [7:0]  nn, vx, vy;
   logic [11:0] nnn;
   logic [4:0]  cnt_last;

   assign hi  = req_ff.instr[15:12];
   assign x   = req_ff.instr[11:8];
   assign y   = req_ff.instr[7:4];
   assign n   = req_ff.instr[3:0];
   assign nn  = req_ff.instr[7:0];
   assign nnn = req_ff.instr[11:0];
   assign vx  = gp_ff[x];
   assign vy  = gp_ff[y];
   assign cnt_last = ({1'b0, x} > FLAG_LAST) ? FLAG_LAST : {1'b0, x};

   assign status_out.save_op    = (hi == 4'hF) && (nn == 8'h75);
   assign status_out.restore_op = (hi == 4'hF) && (nn == 8'h85);
   assign status_out.walk_last  = cnt_last[3:0];

   // combinational execute results
   logic [2:0]  e_status;
   logic [15:0] e_pc, e_index;
   logic        e_wr, e_vf_wr, e_skip, e_push, e_pop, e_dt_wr, e_st_wr;
   logic [7:0]  e_res, e_vf;
   logic [15:0] pc_inc, ret_pc;
   logic [8:0]  sum9;
   logic [7:0]  src;
   logic        held;
   logic [16:0] isum;

   assign pc_inc = pc_ff + 16'd2;
   assign ret_pc = (level_ff != '0) ? stack_mem[SW'(level_ff - LW'(1))] : 16'h0;

   always_comb begin
      e_status = ST_OK;
      e_pc     = pc_inc;
      e_index  = index_ff;
      e_wr     = 1'b0;
      e_vf_wr  = 1'b0;
      e_vf     = 8'h00;
      e_res    = 8'h00;
      e_skip   = 1'b0;
      e_push   = 1'b0;
      e_pop    = 1'b0;
      e_dt_wr  = 1'b0;
      e_st_wr  = 1'b0;
      sum9     = 9'd0;
      src      = quirk.shift_in_place ? vx : vy;
      held     = (vx < 8'd16) && req_ff.keys_held[vx[3:0]];
      isum     = {1'b0, index_ff} + {9'd0, vx};
      case (hi)
         4'h0: begin
            if (nn == 8'hEE) begin
               if (level_ff == '0) e_status = ST_STACK;
               else begin
                  e_pop = 1'b1;
                  e_pc  = ret_pc;
               end
            end else if (nn == 8'hFD) begin
               e_pc = pc_ff;
            end else if (nn == 8'hE0 || nn == 8'hFF || nn == 8'hFE || nn == 8'hFB ||
                         nn == 8'hFC || y == 4'hC) begin
               e_status = ST_OUTSIDE;
            end else e_status = ST_UNDEF;
         end
         4'h1: e_pc = {4'h0, nnn};
         4'h2: begin
            if (level_ff >= LW'(STACK_DEPTH)) e_status = ST_STACK;
            else begin
               e_push = 1'b1;
               e_pc   = {4'h0, nnn};
            end
         end
         4'h3: e_skip = (vx == nn);
         4'h4: e_skip = (vx != nn);
         4'h5: e_skip = (vx == vy);
         4'h6: begin e_res = nn; e_wr = 1'b1; end
         4'h7: begin e_res = vx + nn; e_wr = 1'b1; end
         4'h8: begin
            case (n)
               4'h0: begin e_res = vy; e_wr = 1'b1; end
               4'h1, 4'h2, 4'h3: begin
                  e_res   = (n == 4'h1) ? (vx | vy) : (n == 4'h2) ? (vx & vy) : (vx ^ vy);
                  e_wr    = 1'b1;
                  e_vf_wr = quirk.vf_reset_quirk;
               end
               4'h4: begin
                  sum9 = {1'b0, vx} + {1'b0, vy};
                  e_res = sum9[7:0]; e_vf = {7'd0, sum9[8]};
                  e_wr = 1'b1; e_vf_wr = 1'b1;
               end
               4'h5: begin
                  e_res = vx - vy; e_vf = {7'd0, vx >= vy};
                  e_wr = 1'b1; e_vf_wr = 1'b1;
               end
               4'h7: begin
                  e_res = vy - vx; e_vf = {7'd0, vy >= vx};
                  e_wr = 1'b1; e_vf_wr = 1'b1;
               end
               4'h6: begin
                  e_res = {1'b0, src[7:1]}; e_vf = {7'd0, src[0]};
                  e_wr = 1'b1; e_vf_wr = 1'b1;
               end
               4'hE: begin
                  e_res = {src[6:0], 1'b0}; e_vf = {7'd0, src[7]};
                  e_wr = 1'b1; e_vf_wr = 1'b1;
               end
               default: e_status = ST_UNDEF;
            endcase
         end
         4'h9: e_skip = (vx != vy);
         4'hA: e_index = {4'h0, nnn};
         4'hB: e_pc = {4'h0, nnn} + {8'h00, (quirk.jump_with_vx ? vx : gp_ff[0])};
         4'hC: begin e_res = req_ff.rand_byte & nn; e_wr = 1'b1; end
         4'hD: e_status = ST_OUTSIDE;
         4'hE: begin
            if (nn == 8'h9E) e_skip = held;
            else if (nn == 8'hA1) e_skip = !held;
            else e_status = ST_UNDEF;
         end
         default: begin
            case (nn)
               8'h07: begin e_res = delay_ff; e_wr = 1'b1; end
               8'h0A: begin
                  if (req_ff.released_key[4]) begin
                     e_pc = pc_ff; e_status = ST_WAIT;
                  end else begin
                     e_res = {4'h0, req_ff.released_key[3:0]}; e_wr = 1'b1;
                  end
               end
               8'h15: e_dt_wr = 1'b1;
               8'h18: e_st_wr = 1'b1;
               8'h1E: begin
                  e_index = isum[15:0];
                  e_vf_wr = quirk.index_overflow_quirk && (isum > INDEX_LIMIT);
               end
               8'h29, 8'h30, 8'h33, 8'h55, 8'h65: e_status = ST_OUTSIDE;
               default: e_status = ST_UNDEF;
            endcase
         end
      endcase
      if (e_skip) e_pc = pc_inc + 16'd2;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_in;
      if (cmd.exec && e_push) stack_mem[SW'(level_ff)] <= pc_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) gp_ff[i] <= 8'h00;
         for (int i = 0; i < FLAG_REGS; i++) saved_ff[i] <= 8'h00;
         pc_ff     <= PC_RESET;
         index_ff  <= 16'h0;
         delay_ff  <= 8'h00;
         sound_ff  <= 8'h00;
         level_ff  <= '0;
         status_ff <= ST_OK;
         dreg_ff   <= 4'h0;
         dwr_ff    <= 1'b0;
         skip_ff   <= 1'b0;
      end else begin
         if (cmd.tick) begin
            if (delay_ff != 8'h00) delay_ff <= delay_ff - 8'd1;
            if (sound_ff != 8'h00) sound_ff <= sound_ff - 8'd1;
            status_ff <= ST_OK; dreg_ff <= 4'h0; dwr_ff <= 1'b0; skip_ff <= 1'b0;
         end
         if (cmd.exec) begin
            pc_ff     <= e_pc;
            index_ff  <= e_index;
            status_ff <= e_status;
            skip_ff   <= e_skip;
            dreg_ff   <= e_wr ? x : 4'h0;
            dwr_ff    <= e_wr;
            // the flag wins when x is VF
            if (e_wr && !(e_vf_wr && x == 4'hF)) gp_ff[x] <= e_res;
            if (e_vf_wr) gp_ff[15] <= e_vf;
            if (e_dt_wr) delay_ff <= vx;
            if (e_st_wr) sound_ff <= vx;
            if (e_push) level_ff <= level_ff + LW'(1);
            if (e_pop)  level_ff <= level_ff - LW'(1);
         end
         if (cmd.save || cmd.restore) begin
            // flag walks: the x-nibble decode leaves pc advanced only
            pc_ff     <= (cmd.walk == 4'h0) ? pc_inc : pc_ff;
            status_ff <= ST_OK;
            skip_ff   <= 1'b0;
            dreg_ff   <= cmd.restore ? cmd.walk : 4'h0;
            dwr_ff    <= cmd.restore;
         end
         if (cmd.save) saved_ff[FW'(cmd.walk)] <= gp_ff[cmd.walk];
         if (cmd.restore) gp_ff[cmd.walk] <= saved_ff[FW'(cmd.walk)];
      end
   end

   assign result.status      = status_ff;
   assign result.pc_out      = pc_ff;
   assign result.index_out   = index_ff;
   assign result.dest_reg    = dreg_ff;
   assign result.dest_value  = dwr_ff ? gp_ff[dreg_ff] : 8'h00;
   assign result.flag_value  = gp_ff[15];
   assign result.skipped     = skip_ff;
   assign result.delay_value = delay_ff;
   assign result.sound_on    = (sound_ff != 8'h00);
   assign level_out          = level_ff;
endmodule

FILE: rtl/c8eu_rsp_reg.sv
module c8eu_rsp_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  c8eu_pkg::rsp_payload_type data_in,
   output logic                      slot_free,
   output logic                      valid,
   input  logic                      ready,
   output c8eu_pkg::rsp_payload_type data_out
);
   import c8eu_pkg::*;

   logic            valid_ff;
   rsp_payload_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (load) valid_ff <= 1'b1;
      else if (ready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= data_in;
   end

   assign slot_free = !valid_ff || ready;
   assign valid     = valid_ff;
   assign data_out  = data_ff;
endmodule

FILE: rtl/chip8_execute_unit.sv
// Interpreter core for one CHIP-8 style instruction per request transaction: a tick
// transaction (op 1) decrements the timers; an execute transaction advances pc, runs the
// word and returns one response transaction with status, pc, I, the written register, VF
// and timer view. Fx75 and Fx85 walk min(x+1, FLAG_REGS) flag registers one per cycle.
// A new request is taken only once the previous response has been loaded into the output
// register; a response left waiting there holds the unit in its done state. Memory,
// display and font opcodes answer "left to outside" and touch no state but pc, which
// advances. The user must write quirk bits on the csr channel only while the unit is
// idle; the block itself does not enforce this.
module chip8_execute_unit #(
   parameter int STACK_DEPTH = c8eu_pkg::STACK_DEPTH_DEFAULT,
   parameter int FLAG_REGS   = c8eu_pkg::FLAG_REGS_DEFAULT
) (
   input logic clock,
   input logic reset,
   c8eu_req_if.sink   req,
   c8eu_rsp_if.source rsp,
   c8eu_csr_if.sink   csr
);
   import c8eu_pkg::*;

   localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);

   dp_cmd_type      cmd;
   dp_status_type   dp_status;
   fsm_state_type   state;
   req_payload_type req_payload;
   rsp_payload_type dp_result, rsp_data;
   quirk_type       quirk_ff;
   logic            slot_free;
   logic [LEVEL_W-1:0] level;

   // quirk registers; the port always takes writes
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         quirk_ff <= '{vf_reset_quirk: 1'b1, shift_in_place: 1'b0,
                       jump_with_vx: 1'b0, index_overflow_quirk: 1'b0};
      end else if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_VF_RESET:  quirk_ff.vf_reset_quirk       <= csr.data;
            CSR_SHIFT:     quirk_ff.shift_in_place       <= csr.data;
            CSR_JUMP_VX:   quirk_ff.jump_with_vx         <= csr.data;
            CSR_INDEX_OVF: quirk_ff.index_overflow_quirk <= csr.data;
            default: ;
         endcase
      end
   end

   assign req_payload.instr        = req.instr;
   assign req_payload.keys_held    = req.keys_held;
   assign req_payload.released_key = req.released_key;
   assign req_payload.rand_byte    = req.rand_byte;

   c8eu_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_op(req.op), .req_ready(req.ready),
      .rsp_slot_free(slot_free), .status_in(dp_status), .cmd, .state_out(state)
   );

   c8eu_datapath #(.STACK_DEPTH(STACK_DEPTH), .FLAG_REGS(FLAG_REGS)) u_dp (
      .clock, .reset, .cmd, .req_in(req_payload), .quirk(quirk_ff),
      .status_out(dp_status), .result(dp_result), .level_out(level)
   );

   // hold the response transaction until the sink takes it
   c8eu_rsp_reg u_rsp (
      .clock, .reset, .load(cmd.emit), .data_in(dp_result),
      .slot_free, .valid(rsp.valid), .ready(rsp.ready), .data_out(rsp_data)
   );

   assign rsp.status      = rsp_data.status;
   assign rsp.pc_out      = rsp_data.pc_out;
   assign rsp.index_out   = rsp_data.index_out;
   assign rsp.dest_reg    = rsp_data.dest_reg;
   assign rsp.dest_value  = rsp_data.dest_value;
   assign rsp.flag_value  = rsp_data.flag_value;
   assign rsp.skipped     = rsp_data.skipped;
   assign rsp.delay_value = rsp_data.delay_value;
   assign rsp.sound_on    = rsp_data.sound_on;

   // stack level never exceeds its depth
   a_level: assert property (@(posedge clock) disable iff (reset)
      level <= LEVEL_W'(STACK_DEPTH))
      else $error("stack level out of range");

   // only idle state takes a request
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state == FSM_IDLE)
      else $error("request taken outside idle");

   // a loaded response raises valid
   a_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp.valid)
      else $error("response lost");
endmodule

FILE: dv/tb_chip8_execute_unit.sv
module tb_chip8_execute_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import c8eu_pkg::*;

   localparam int STK = STACK_DEPTH_DEFAULT;
   localparam int FLG = FLAG_REGS_DEFAULT;

   logic clock;
   logic reset;

   c8eu_req_if req ();
   c8eu_rsp_if rsp ();
   c8eu_csr_if csr ();

   chip8_execute_unit uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   // Mirror of the interpreter state kept by the predictor.
   logic [7:0]  mdl_v [16];
   logic [15:0] mdl_pc;
   logic [15:0] mdl_i;
   logic [7:0]  mdl_dt;
   logic [7:0]  mdl_st;
   logic [15:0] mdl_stack [STK];
   int          mdl_sp;
   logic [7:0]  mdl_saved [FLG];
   quirk_type   mdl_q;

   rsp_payload_type expected_rsp_q [$];

   int n_mismatch;
   int n_rsp;
   int n_tx;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_rsp;
   int hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous limit for ~1180 items, several times over.
   initial begin
      #20ms;
      $display("chip8_execute_unit test failed");
      $finish;
   end

   function automatic void model_reset();
      for (int k = 0; k < 16; k++) mdl_v[k] = '0;
      for (int k = 0; k < STK; k++) mdl_stack[k] = '0;
      for (int k = 0; k < FLG; k++) mdl_saved[k] = '0;
      mdl_pc = PC_RESET;
      mdl_i  = '0;
      mdl_dt = '0;
      mdl_st = '0;
      mdl_sp = 0;
      mdl_q  = '{vf_reset_quirk: 1'b1, shift_in_place: 1'b0, jump_with_vx: 1'b0,
                 index_overflow_quirk: 1'b0};
   endfunction

   // Work out the response to one transaction and advance the mirrored state.
   function automatic rsp_payload_type execute_instr(logic op, req_payload_type p);
      rsp_payload_type r;
      logic [3:0] hi, x, y, n;
      logic [7:0] nn, vx, vy, res, src;
      logic [11:0] nnn;
      logic flag, skip, plain, alu, held;
      status_type st;
      logic [3:0] dreg;
      logic [7:0] dval;
      int cnt;
      logic [8:0] sum;
      st = ST_OK; dreg = '0; dval = '0; skip = 1'b0; plain = 1'b0; alu = 1'b0;
      res = '0; flag = 1'b0;
      if (op) begin
         if (mdl_dt != 0) mdl_dt--;
         if (mdl_st != 0) mdl_st--;
      end else begin
         {hi, x, y, n} = p.instr;
         nn = p.instr[7:0];
         nnn = p.instr[11:0];
         vx = mdl_v[x];
         vy = mdl_v[y];
         mdl_pc += 16'd2;
         case (hi)
            4'h0: begin
               if (nn == 8'hEE) begin
                  if (mdl_sp == 0) st = ST_STACK;
                  else begin
                     mdl_sp--;
                     mdl_pc = mdl_stack[mdl_sp];
                  end
               end else if (nn == 8'hFD) mdl_pc -= 16'd2;
               else if (nn inside {8'hE0, 8'hFF, 8'hFE, 8'hFB, 8'hFC} || y == 4'hC)
                  st = ST_OUTSIDE;
               else st = ST_UNDEF;
            end
            4'h1: mdl_pc = {4'h0, nnn};
            4'h2: begin
               if (mdl_sp >= STK) st = ST_STACK;
               else begin
                  mdl_stack[mdl_sp] = mdl_pc;
                  mdl_sp++;
                  mdl_pc = {4'h0, nnn};
               end
            end
            4'h3: skip = (vx == nn);
            4'h4: skip = (vx != nn);
            4'h5: skip = (vx == vy);
            4'h6: begin res = nn; plain = 1'b1; end
            4'h7: begin res = vx + nn; plain = 1'b1; end
            4'h8: begin
               case (n)
                  4'h0: begin res = vy; plain = 1'b1; end
                  4'h1, 4'h2, 4'h3: begin
                     res = (n == 4'h1) ? (vx | vy) : (n == 4'h2) ? (vx & vy) : (vx ^ vy);
                     mdl_v[x] = res;
                     if (mdl_q.vf_reset_quirk) mdl_v[15] = '0;
                     dreg = x; dval = mdl_v[x];
                  end
                  4'h4: begin sum = vx + vy; flag = sum[8]; res = sum[7:0]; alu = 1'b1; end
                  4'h5: begin flag = (vx >= vy); res = vx - vy; alu = 1'b1; end
                  4'h7: begin flag = (vy >= vx); res = vy - vx; alu = 1'b1; end
                  4'h6, 4'hE: begin
                     src = mdl_q.shift_in_place ? vx : vy;
                     if (n == 4'h6) begin flag = src[0]; res = src >> 1; end
                     else begin flag = src[7]; res = src << 1; end
                     alu = 1'b1;
                  end
                  default: st = ST_UNDEF;
               endcase
            end
            4'h9: skip = (vx != vy);
            4'hA: mdl_i = {4'h0, nnn};
            4'hB: mdl_pc = {4'h0, nnn} + (mdl_q.jump_with_vx ? vx : mdl_v[0]);
            4'hC: begin res = p.rand_byte & nn; plain = 1'b1; end
            4'hD: st = ST_OUTSIDE;
            4'hE: begin
               if (nn == 8'h9E || nn == 8'hA1) begin
                  held = (vx < 16) && p.keys_held[vx[3:0]];
                  skip = (nn == 8'h9E) ? held : !held;
               end else st = ST_UNDEF;
            end
            default: begin
               case (nn)
                  8'h07: begin res = mdl_dt; plain = 1'b1; end
                  8'h0A: begin
                     if (p.released_key >= 16) begin
                        mdl_pc -= 16'd2;
                        st = ST_WAIT;
                     end else begin
                        res = {3'b0, p.released_key}; plain = 1'b1;
                     end
                  end
                  8'h15: mdl_dt = vx;
                  8'h18: mdl_st = vx;
                  8'h1E: begin
                     if (mdl_q.index_overflow_quirk && (int'(mdl_i) + int'(vx) > 999))
                        mdl_v[15] = '0;
                     mdl_i += vx;
                  end
                  8'h29, 8'h30, 8'h33, 8'h55, 8'h65: st = ST_OUTSIDE;
                  8'h75: begin
                     cnt = (int'(x) + 1 > FLG) ? FLG : int'(x) + 1;
                     for (int k = 0; k < cnt; k++) mdl_saved[k] = mdl_v[k];
                  end
                  8'h85: begin
                     cnt = (int'(x) + 1 > FLG) ? FLG : int'(x) + 1;
                     for (int k = 0; k < cnt; k++) mdl_v[k] = mdl_saved[k];
                     dreg = 4'(cnt - 1); dval = mdl_v[dreg];
                  end
                  default: st = ST_UNDEF;
               endcase
            end
         endcase
         if (skip) mdl_pc += 16'd2;
         if (plain) begin
            mdl_v[x] = res; dreg = x; dval = res;
         end
         if (alu) begin
            mdl_v[x] = res; mdl_v[15] = {7'b0, flag}; dreg = x; dval = mdl_v[x];
         end
      end
      r.status = st;
      r.pc_out = mdl_pc;
      r.index_out = mdl_i;
      r.dest_reg = dreg;
      r.dest_value = dval;
      r.flag_value = mdl_v[15];
      r.skipped = skip;
      r.delay_value = mdl_dt;
      r.sound_on = (mdl_st != 0);
      return r;
   endfunction

   // Drive one request transaction and hold it until accepted; queue its prediction.
   // Valid stays high afterwards so that the next item can follow back to back.
   task automatic send_item(logic op, req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.op <= op;
      req.instr <= p.instr;
      req.keys_held <= p.keys_held;
      req.released_key <= p.released_key;
      req.rand_byte <= p.rand_byte;
      do @(posedge clock); while (!req.ready);
      expected_rsp_q.push_back(execute_instr(op, p));
      n_tx++;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write one quirk bit; only called with the unit idle. Valid is dropped by the caller.
   task automatic write_quirk(csr_index_type idx, logic val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         CSR_VF_RESET:  mdl_q.vf_reset_quirk = val;
         CSR_SHIFT:     mdl_q.shift_in_place = val;
         CSR_JUMP_VX:   mdl_q.jump_with_vx = val;
         CSR_INDEX_OVF: mdl_q.index_overflow_quirk = val;
         default: ;
      endcase
   endtask

   // Random instruction word, biased towards opcodes the unit actually runs.
   function automatic req_payload_type random_item();
      req_payload_type p;
      logic [3:0] x;
      int sel;
      p.keys_held = 16'($urandom);
      p.rand_byte = 8'($urandom);
      p.released_key = ($urandom_range(3) == 0) ? 5'($urandom_range(16, 31))
                                                : 5'($urandom_range(15));
      x = 4'($urandom);
      sel = $urandom_range(99);
      if (sel < 10) p.instr = {4'h8, x, 4'($urandom), 4'($urandom)};
      else if (sel < 20) p.instr = {4'h6, x, 8'($urandom)};
      else if (sel < 26) p.instr = {4'h7, x, 8'($urandom)};
      else if (sel < 36) begin
         case ($urandom_range(10))
            0: p.instr = {4'hF, x, 8'h07};
            1: p.instr = {4'hF, x, 8'h0A};
            2: p.instr = {4'hF, x, 8'h15};
            3: p.instr = {4'hF, x, 8'h18};
            4: p.instr = {4'hF, x, 8'h1E};
            5: p.instr = {4'hF, x, 8'h75};
            6: p.instr = {4'hF, x, 8'h85};
            7: p.instr = {4'hF, x, 8'h33};
            default: p.instr = {4'hF, x, 8'($urandom)};
         endcase
      end else if (sel < 44) p.instr = {4'hE, x, ($urandom_range(2) == 0) ? 8'($urandom) :
                                        ($urandom_range(1) ? 8'h9E : 8'hA1)};
      else if (sel < 50) p.instr = {8'h00, ($urandom_range(1) ? 8'hEE : 8'($urandom))};
      else if (sel < 56) p.instr = {4'h2, 12'($urandom)};
      else if (sel < 62) p.instr = {4'h0, 4'($urandom), 8'($urandom)};
      else p.instr = 16'($urandom);
      return p;
   endfunction

   // Directed rows: expected response typed in only where obvious, otherwise predicted.
   typedef struct {
      logic op;
      logic [15:0] instr;
      logic [15:0] keys;
      logic [4:0] rkey;
      logic [7:0] rbyte;
      bit typed;
      status_type st;
      logic [15:0] pc;
   } stim_row_type;

   stim_row_type stim_table [] = '{
      '{1'b1, 16'h0000, 16'h0000, 5'd16, 8'h00, 1, ST_OK,      16'h0200},
      '{1'b0, 16'h00EE, 16'h0000, 5'd16, 8'h00, 1, ST_STACK,   16'h0202},
      '{1'b0, 16'h0000, 16'hFFFF, 5'd31, 8'hFF, 1, ST_UNDEF,   16'h0204},
      '{1'b0, 16'h00E0, 16'h0000, 5'd16, 8'h00, 1, ST_OUTSIDE, 16'h0206},
      '{1'b0, 16'h00C3, 16'h0000, 5'd16, 8'h00, 1, ST_OUTSIDE, 16'h0208},
      '{1'b0, 16'h00FD, 16'h0000, 5'd16, 8'h00, 1, ST_OK,      16'h0208},
      '{1'b0, 16'hF00A, 16'h0000, 5'd16, 8'h00, 1, ST_WAIT,    16'h0208},
      '{1'b0, 16'h6AFF, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h6B01, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h8AB4, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h8AB5, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h8BA7, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h8FA6, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h8AAE, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h8AB1, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h6C20, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'hEC9E, 16'hFFFF, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'hECA1, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h5AB7, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'hCDFF, 16'h0000, 5'd16, 8'hA5, 0, ST_OK, 16'h0},
      '{1'b0, 16'hFF75, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'hFF85, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h2FFE, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'h00EE, 16'h0000, 5'd16, 8'h00, 0, ST_OK, 16'h0},
      '{1'b0, 16'hBFFF, 16'h0000, 5'd0,  8'h00, 0, ST_OK, 16'h0}
   };

   // Response side: random stall, plus a long hold-off when asked; check in order.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            n_rsp++;
            if (expected_rsp_q.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10) $display("unexpected response transaction");
            end else begin
               want = expected_rsp_q.pop_front();
               if ({rsp.status, rsp.pc_out, rsp.index_out, rsp.dest_reg, rsp.dest_value,
                    rsp.flag_value, rsp.skipped, rsp.delay_value, rsp.sound_on} !== want) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("mismatch: exp st=%0d pc=%h i=%h d=%0d/%h vf=%h sk=%b dt=%h snd=%b",
                              want.status, want.pc_out, want.index_out, want.dest_reg,
                              want.dest_value, want.flag_value, want.skipped,
                              want.delay_value, want.sound_on,
                              "\n          got st=%0d pc=%h i=%h d=%0d/%h vf=%h sk=%b dt=%h snd=%b",
                              rsp.status, rsp.pc_out, rsp.index_out, rsp.dest_reg,
                              rsp.dest_value, rsp.flag_value, rsp.skipped, rsp.delay_value,
                              rsp.sound_on);
               end
            end
         end
         // Long hold-off is counted here so that the sender keeps offering meanwhile.
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= 300) hold_rsp <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      req_payload_type p;
      rsp_payload_type want;
      n_mismatch = 0; n_rsp = 0; n_tx = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      hold_rsp = 1'b0; hold_cycles = 0;
      req.valid = 1'b0; req.op = 1'b0; req.instr = '0; req.keys_held = '0;
      req.released_key = '0; req.rand_byte = '0;
      csr.valid = 1'b0; csr.index = CSR_VF_RESET; csr.data = 1'b0;
      model_reset();
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: typed rows override the predicted status and pc.
      foreach (stim_table[k]) begin
         p.instr = stim_table[k].instr;
         p.keys_held = stim_table[k].keys;
         p.released_key = stim_table[k].rkey;
         p.rand_byte = stim_table[k].rbyte;
         send_item(stim_table[k].op, p);
         if (stim_table[k].typed) begin
            want = expected_rsp_q.pop_back();
            if (want.status != stim_table[k].st || want.pc_out != stim_table[k].pc) begin
               n_mismatch++;
               $display("directed row %0d: predictor disagrees with typed value", k);
            end
            want.status = stim_table[k].st;
            want.pc_out = stim_table[k].pc;
            expected_rsp_q.push_back(want);
         end
      end
      drain();

      // Fill the call stack to overflow, then unwind past empty.
      for (int k = 0; k <= STK; k++) begin
         p = random_item(); p.instr = {4'h2, 12'($urandom)};
         send_item(1'b0, p);
      end
      for (int k = 0; k <= STK; k++) begin
         p = random_item(); p.instr = 16'h00EE;
         send_item(1'b0, p);
      end
      drain();

      // Random phases across quirk settings and idling mixes.
      for (int ph = 0; ph < 8; ph++) begin
         write_quirk(CSR_VF_RESET, ph[0]);
         write_quirk(CSR_SHIFT, ph[1]);
         write_quirk(CSR_JUMP_VX, ph[2]);
         write_quirk(CSR_INDEX_OVF, ph[0] ^ ph[2]);
         csr.valid <= 1'b0;
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         if (ph == 4) begin
            hold_cycles = 0;
            hold_rsp = 1'b1;
         end
         for (int k = 0; k < 140; k++) begin
            p = random_item();
            send_item(($urandom_range(9) == 0), p);
         end
         drain();
      end

      $display("ran %0d request transactions over 8 quirk settings, %0d responses checked",
               n_tx, n_rsp);
      if (n_mismatch == 0 && expected_rsp_q.size() == 0) begin
         $display("chip8_execute_unit test passed");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", n_mismatch,
                  expected_rsp_q.size());
         $display("chip8_execute_unit test failed");
      end
      $finish;
   end
endmodule
